/* design/tdq_pkg.sv */
// Shared types, constants and helpers for the timer deadline queue.
package tdq_pkg;

    localparam int DEPTH    = 16;
    localparam int ID_WIDTH = 8;
    localparam int DL_W     = 32;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // request modes
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_CHECK  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_ZERO      = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INS,
        OP_DEL,
        OP_POP
    } tdq_op_t;

    typedef struct packed {
        tdq_op_t               op;
        logic [DL_W-1:0]       dl;
        logic [ID_WIDTH-1:0]   id;
    } tdq_cmd_t;

    // a is later than b when (a - b) read as signed is above zero
    function automatic logic later_than(input logic [DL_W-1:0] a,
                                        input logic [DL_W-1:0] b);
        logic [DL_W-1:0] d;
        begin
            d = a - b;
            return (d != '0) && !d[DL_W-1];
        end
    endfunction

    // take the low ID_WIDTH bits of an 8-bit port id
    function automatic logic [ID_WIDTH-1:0] to_id(input logic [7:0] w);
        logic [ID_WIDTH+7:0] t;
        begin
            t = (ID_WIDTH + 8)'(w);
            return t[ID_WIDTH-1:0];
        end
    endfunction

    // bring a stored id back to the 8-bit port width
    function automatic logic [7:0] from_id(input logic [ID_WIDTH-1:0] v);
        logic [ID_WIDTH+7:0] t;
        begin
            t = (ID_WIDTH + 8)'(v);
            return t[7:0];
        end
    endfunction

endpackage

/* design/tdq_cell.sv */
// One slot of the sorted deadline chain: holds an entry and trades with its neighbors.
module tdq_cell (
    input  logic                          aclk,
    input  tdq_pkg::tdq_cmd_t             cmd,
    input  logic                          occ,
    input  logic                          chain_in,
    output logic                          chain_out,
    input  logic [tdq_pkg::DL_W-1:0]      left_dl,
    input  logic [tdq_pkg::ID_WIDTH-1:0]  left_id,
    input  logic [tdq_pkg::DL_W-1:0]      right_dl,
    input  logic [tdq_pkg::ID_WIDTH-1:0]  right_id,
    output logic [tdq_pkg::DL_W-1:0]      dl,
    output logic [tdq_pkg::ID_WIDTH-1:0]  id
);
    import tdq_pkg::*;

    logic [DL_W-1:0]     dl_reg, dl_next;
    logic [ID_WIDTH-1:0] id_reg, id_next;
    logic                hit;

    always_comb begin
        case (cmd.op)
            OP_INS:  hit = !occ || later_than(dl_reg, cmd.dl);
            OP_DEL:  hit = occ && (id_reg == cmd.id);
            OP_POP:  hit = 1'b1;
            default: hit = 1'b0;
        endcase
        chain_out = chain_in | hit;
    end

    always_comb begin
        dl_next = dl_reg;
        id_next = id_reg;
        case (cmd.op)
            OP_INS: begin
                // shift right past the insertion point, drop the new entry in at it
                if (chain_in) begin
                    dl_next = left_dl;
                    id_next = left_id;
                end else if (hit) begin
                    dl_next = cmd.dl;
                    id_next = cmd.id;
                end
            end
            OP_DEL, OP_POP: begin
                // close the gap from the removed slot onward
                if (chain_out) begin
                    dl_next = right_dl;
                    id_next = right_id;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        dl_reg <= dl_next;
        id_reg <= id_next;
    end

    assign dl = dl_reg;
    assign id = id_reg;

endmodule

/* design/timer_deadline_queue_top.sv */
// Top level of the timer deadline queue: request sequencer, cell chain and result register.
// A request is taken while the sequencer is idle; its first result is registered on the first step.
// Add, remove and unused modes give one result per request; check gives one result per expired
// head plus a last one, one result per cycle while m_ready does not stall, from the single head pop per step.
// Every operation is one step of the cell chain, so stalls on m_ready hold the chain back.
// Reset: aresetn (synchronous, active low) empties the queue and clears the handshake state;
// the stored deadlines and ids are not cleared and are never read before being written.
module timer_deadline_queue_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_waiter_id,
    input  logic [31:0] s_now,
    input  logic [30:0] s_delay,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_became_head,
    output logic        m_expired,
    output logic [7:0]  m_released_id,
    output logic [30:0] m_time_to_next,
    output logic        m_last
);
    import tdq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } state_t;

    state_t              state_reg;
    logic [1:0]          mode_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic [DL_W-1:0]     now_reg;
    logic [30:0]         delay_reg;
    logic [CNT_W-1:0]    count_reg, count_next;

    logic        m_valid_reg;
    logic [1:0]  status_reg, status_next;
    logic        head_reg, head_next;
    logic        exp_reg, exp_next;
    logic [7:0]  rid_reg, rid_next;
    logic [30:0] ttn_reg, ttn_next;
    logic        last_reg, last_next;

    // chain wiring
    tdq_cmd_t            cmd;
    tdq_op_t             op_want;
    logic [DL_W-1:0]     cell_dl [DEPTH];
    logic [ID_WIDTH-1:0] cell_id [DEPTH];
    logic [DEPTH:0]      chain;
    logic [DL_W-1:0]     new_dl;
    logic [DL_W-1:0]     head_gap;
    logic                out_free;
    logic                step;
    logic                done;

    assign out_free = !m_valid_reg || m_ready;
    assign step     = (state_reg == S_BUSY) && out_free;
    assign s_ready  = (state_reg == S_IDLE);
    assign new_dl   = now_reg + DL_W'(delay_reg);
    assign head_gap = cell_dl[0] - now_reg;
    assign chain[0] = 1'b0;

    // decide what the current step does to the chain and what it reports
    always_comb begin
        op_want     = OP_HOLD;
        count_next  = count_reg;
        status_next = ST_OK;
        head_next   = 1'b0;
        exp_next    = 1'b0;
        rid_next    = '0;
        ttn_next    = '0;
        last_next   = 1'b1;
        case (mode_reg)
            MODE_ADD: begin
                if (delay_reg == '0) begin
                    status_next = ST_ZERO;
                end else if (count_reg == CNT_W'(DEPTH)) begin
                    status_next = ST_FULL;
                end else begin
                    op_want    = OP_INS;
                    count_next = count_reg + 1'b1;
                    // the new entry lands in slot 0 exactly when that slot takes it
                    head_next  = chain[1];
                end
            end
            MODE_REMOVE: begin
                op_want = OP_DEL;
                if (chain[DEPTH]) begin
                    count_next = count_reg - 1'b1;
                    rid_next   = from_id(id_reg);
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            MODE_CHECK: begin
                if (count_reg == '0) begin
                    ttn_next = '0;
                end else if (later_than(cell_dl[0], now_reg)) begin
                    ttn_next = head_gap[30:0];
                end else begin
                    // release the expired head and stay on this request
                    op_want    = OP_POP;
                    count_next = count_reg - 1'b1;
                    exp_next   = 1'b1;
                    rid_next   = from_id(cell_id[0]);
                    last_next  = 1'b0;
                end
            end
            default: begin
            end
        endcase
        done = last_next;
    end

    always_comb begin
        cmd.op = step ? op_want : OP_HOLD;
        cmd.dl = new_dl;
        cmd.id = id_reg;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DL_W-1:0]     l_dl, r_dl;
        logic [ID_WIDTH-1:0] l_id, r_id;
        logic                occ;

        assign occ = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_first
            assign l_dl = new_dl;
            assign l_id = id_reg;
        end else begin : g_mid
            assign l_dl = cell_dl[i-1];
            assign l_id = cell_id[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign r_dl = cell_dl[i];
            assign r_id = cell_id[i];
        end else begin : g_body
            assign r_dl = cell_dl[i+1];
            assign r_id = cell_id[i+1];
        end

        tdq_cell u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .occ       (occ),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .left_dl   (l_dl),
            .left_id   (l_id),
            .right_dl  (r_dl),
            .right_id  (r_id),
            .dl        (cell_dl[i]),
            .id        (cell_id[i])
        );
    end

    // sequencer, entry count and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // load a new result on a step, otherwise drop valid once it is taken
            if (step) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    if (step) begin
                        count_reg  <= count_next;
                        status_reg <= status_next;
                        head_reg   <= head_next;
                        exp_reg    <= exp_next;
                        rid_reg    <= rid_next;
                        ttn_reg    <= ttn_next;
                        last_reg   <= last_next;
                        if (done) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // hold the request fields
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg  <= s_mode;
            id_reg    <= to_id(s_waiter_id);
            now_reg   <= s_now;
            delay_reg <= s_delay;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_became_head  = head_reg;
    assign m_expired      = exp_reg;
    assign m_released_id  = rid_reg;
    assign m_time_to_next = ttn_reg;
    assign m_last         = last_reg;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the timer deadline queue: directed and random requests.
module tb_top;
    import tdq_pkg::*;

    // mode 3 has no name in the package; the block answers it with one empty result
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int          RANDOM_ITEMS = 410;
    localparam int          CALM_TAIL    = 40;    // last requests go out with no idling
    localparam int          QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int          DRAIN_CYCLES = 24;
    localparam logic [31:0] WRAP_BASE    = 32'hFFFF_FFF0;

    // delays for the directed fill: equal deadlines, both wrap sides, the longest delay
    localparam logic [30:0] FILL_DELAY [16] = '{
        31'd20, 31'd5, 31'd5, 31'd40, 31'd1, 31'h7FFF_FFFF, 31'd100, 31'd5,
        31'd60, 31'd2, 31'd300, 31'd1000, 31'd20, 31'd7, 31'h4000_0000, 31'd500
    };

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  waiter_id;
        logic [31:0] now;
        logic [30:0] delay;
    } tq_request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        became_head;
        logic        expired;
        logic [7:0]  released_id;
        logic [30:0] time_to_next;
        logic        last;
    } tq_outcome_t;

    // clock, reset and ports; every block input starts at a known value
    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode         = '0;
    logic [7:0]  s_waiter_id    = '0;
    logic [31:0] s_now          = '0;
    logic [30:0] s_delay        = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [1:0]  m_status;
    logic        m_became_head;
    logic        m_expired;
    logic [7:0]  m_released_id;
    logic [30:0] m_time_to_next;
    logic        m_last;

    timer_deadline_queue_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_waiter_id    (s_waiter_id),
        .s_now          (s_now),
        .s_delay        (s_delay),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_became_head  (m_became_head),
        .m_expired      (m_expired),
        .m_released_id  (m_released_id),
        .m_time_to_next (m_time_to_next),
        .m_last         (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // requests waiting to be driven, and results the predictor says must come back
    tq_request_t request_backlog [$];
    tq_outcome_t due_results [$];

    // predicted queue contents, sorted by deadline, head at index 0
    logic [31:0]         held_due [DEPTH];
    logic [ID_WIDTH-1:0] held_who [DEPTH];
    int                  held_count = 0;

    // handshake flags, sampled at the rising edge and read at the falling edge
    bit req_fired = 1'b0;
    bit res_fired = 1'b0;
    bit run_live  = 1'b0;
    bit calm      = 1'b0;
    bit draining  = 1'b0;

    // idling state for both sides
    int src_gap_left   = 0;
    bit src_rested     = 1'b0;
    int src_odds       = 4;
    int snk_stall_left = 0;
    bit snk_rested     = 1'b0;
    int sink_odds      = 4;

    // bookkeeping
    int quiet_cycles    = 0;
    int mismatches      = 0;
    int requests_taken  = 0;
    int results_seen    = 0;
    int releases_seen   = 0;
    int full_seen       = 0;
    int not_found_seen  = 0;
    int became_head_cnt = 0;

    // wrap-safe ordering: a falls after b when the 32-bit difference is positive as signed
    function automatic bit due_later(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return $signed(d) > 0;
    endfunction

    function automatic int pick_idle_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 12;
        endcase
    endfunction

    function automatic string describe(input tq_outcome_t r);
        return $sformatf("status=%0d head=%0b expired=%0b id=%0d ttn=%0d last=%0b",
                         r.status, r.became_head, r.expired, r.released_id,
                         r.time_to_next, r.last);
    endfunction

    task automatic queue_req(input logic [1:0] mode, input logic [7:0] wid,
                             input logic [31:0] at, input logic [30:0] dly);
        tq_request_t rq;
        rq.mode      = mode;
        rq.waiter_id = wid;
        rq.now       = at;
        rq.delay     = dly;
        request_backlog.push_back(rq);
    endtask

    // close the gap at pos, pulling later entries one place toward the head
    task automatic drop_entry(input int pos);
        for (int i = pos; i + 1 < held_count; i++) begin
            held_due[i] = held_due[i + 1];
            held_who[i] = held_who[i + 1];
        end
        held_count--;
    endtask

    // work out every result one request causes and advance the predicted queue
    task automatic predict_timeouts(input tq_request_t rq);
        logic [ID_WIDTH-1:0] who;
        logic [31:0]         due;
        logic [31:0]         gap;
        int                  pos;
        bit                  found;
        tq_outcome_t         res;
        who   = ID_WIDTH'(rq.waiter_id);
        gap   = '0;
        found = 1'b0;
        res   = '0;
        case (rq.mode)
            MODE_ADD: begin
                if (rq.delay == '0) begin
                    res.status = ST_ZERO;
                end else if (held_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    due = rq.now + {1'b0, rq.delay};
                    pos = held_count;
                    // land after any equal deadlines
                    for (int i = 0; i < held_count; i++) begin
                        if (due_later(held_due[i], due)) begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = held_count; i > pos; i--) begin
                        held_due[i] = held_due[i - 1];
                        held_who[i] = held_who[i - 1];
                    end
                    held_due[pos] = due;
                    held_who[pos] = who;
                    held_count++;
                    res.became_head = (pos == 0);
                end
            end
            MODE_REMOVE: begin
                res.status = ST_NOT_FOUND;
                for (int i = 0; i < held_count; i++) begin
                    if (held_who[i] == who) begin
                        res.status      = ST_OK;
                        res.released_id = 8'(who);
                        drop_entry(i);
                        break;
                    end
                end
            end
            MODE_CHECK: begin
                // release expired heads one by one, then report the distance to the next
                while (held_count > 0 && !found) begin
                    if (due_later(held_due[0], rq.now)) begin
                        gap   = held_due[0] - rq.now;
                        found = 1'b1;
                    end else begin
                        res             = '0;
                        res.expired     = 1'b1;
                        res.released_id = 8'(held_who[0]);
                        due_results.push_back(res);
                        drop_entry(0);
                    end
                end
                res = '0;
                if (found) begin
                    res.time_to_next = gap[30:0];
                end
            end
            default: begin
            end
        endcase
        res.last = 1'b1;
        due_results.push_back(res);
    endtask

    // Rising edge: take the handshakes, predict accepted requests, check results, run the
    // watchdog. Everything here reads values settled since the previous falling edge.
    always @(posedge aclk) begin
        tq_outcome_t got;
        tq_outcome_t want;
        bit          was_due;
        was_due   = 1'b0;
        req_fired = aresetn && s_valid && s_ready;
        res_fired = aresetn && m_valid && m_ready;

        if (req_fired) begin
            predict_timeouts({s_mode, s_waiter_id, s_now, s_delay});
            requests_taken++;
        end

        if (res_fired) begin
            got = {m_status, m_became_head, m_expired, m_released_id, m_time_to_next, m_last};
            results_seen++;
            if (due_results.size() == 0) begin
                // a result nobody asked for
                mismatches++;
                if (mismatches <= 10) begin
                    $display("tb_top: unexpected result at %0t: %s", $realtime, describe(got));
                end
            end else begin
                was_due = 1'b1;
                want = due_results.pop_front();
                if (got.status !== want.status || got.became_head !== want.became_head ||
                    got.expired !== want.expired || got.released_id !== want.released_id ||
                    got.time_to_next !== want.time_to_next || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("tb_top: mismatch at %0t", $realtime);
                        $display("    expected %s", describe(want));
                        $display("    actual   %s", describe(got));
                    end
                end
            end
            if (got.expired === 1'b1) releases_seen++;
            if (got.status === ST_FULL) full_seen++;
            if (got.status === ST_NOT_FOUND) not_found_seen++;
            if (got.became_head === 1'b1) became_head_cnt++;
        end

        // give up when nothing useful moves for too long; stray results do not count
        if (run_live && !draining) begin
            if (req_fired || was_due) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_top: no handshake for %0d cycles, %0d results outstanding",
                         quiet_cycles, due_results.size());
                $display("tb_top: FAIL");
                $finish;
            end
        end

        run_live = aresetn;
        calm     = request_backlog.size() < CALM_TAIL;
    end

    // Request driver: advance to the next request once the current one is taken, hold
    // valid and payload while it waits, and drop valid for bursts of idle cycles.
    always @(negedge aclk) begin
        logic        nv;
        tq_request_t next_req;
        nv = s_valid;
        if (!run_live) begin
            nv = 1'b0;
        end else if (!s_valid || req_fired) begin
            nv = 1'b0;
            if (src_gap_left != 0) begin
                src_gap_left--;
            end else if (request_backlog.size() != 0) begin
                if (!calm && src_odds != 0 && !src_rested &&
                    $urandom_range(1, src_odds) == 1) begin
                    // this cycle stays empty, then as many more as src_gap_left holds
                    src_gap_left = $urandom_range(0, 11);
                    src_rested   = 1'b1;
                end else begin
                    next_req    = request_backlog.pop_front();
                    s_mode      <= next_req.mode;
                    s_waiter_id <= next_req.waiter_id;
                    s_now       <= next_req.now;
                    s_delay     <= next_req.delay;
                    nv          = 1'b1;
                    src_rested  = 1'b0;
                    if ($urandom_range(0, 39) == 0) src_odds = pick_idle_odds();
                end
            end
        end
        s_valid <= nv;
    end

    // Result sink: hold ready low for bursts of random length, never two bursts back to back.
    always @(negedge aclk) begin
        logic nr;
        nr = 1'b1;
        if (snk_stall_left != 0) begin
            snk_stall_left--;
            nr = 1'b0;
        end else if (!calm && sink_odds != 0 && !snk_rested &&
                     $urandom_range(1, sink_odds) == 1) begin
            snk_stall_left = $urandom_range(0, 11);
            nr             = 1'b0;
        end
        snk_rested = !nr;
        if ($urandom_range(0, 49) == 0) sink_odds = pick_idle_odds();
        if (!run_live) nr = 1'b0;
        m_ready <= nr;
    end

    // Stimulus and end of run.
    initial begin
        logic [31:0] sim_now;
        logic [7:0]  wid;
        logic [30:0] dly;
        logic [7:0]  recent [$];
        int          counted;
        int          roll;
        int          k;
        int          add_weight;

        // Directed: empty queue cases, ignored requests, fill to the brim across the
        // wrap point with equal deadlines and a duplicate id, overflow, removals, drains.
        queue_req(MODE_CHECK, 8'h00, 32'h0000_0000, 31'h0);          // check on empty queue
        queue_req(MODE_REMOVE, 8'h05, 32'h0000_0000, 31'h0);         // id not present
        queue_req(MODE_ADD, 8'hA5, 32'hFFFF_FFFF, 31'h0);            // zero delay
        queue_req(MODE_SPARE, 8'hFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);  // unused mode
        for (int i = 0; i < 16; i++) begin
            wid = (i == 0 || i == 12) ? 8'hFF : ((i == 1) ? 8'h00 : 8'(8'h10 + i));
            queue_req(MODE_ADD, wid, WRAP_BASE, FILL_DELAY[i]);
        end
        queue_req(MODE_ADD, 8'h77, WRAP_BASE, 31'd9);                // queue full
        queue_req(MODE_REMOVE, 8'hFF, 32'h0, 31'h0);                 // first of two equal ids
        queue_req(MODE_REMOVE, 8'h12, 32'h0, 31'h0);
        queue_req(MODE_CHECK, 8'h00, 32'h0000_0010, 31'h0);          // several heads expire
        queue_req(MODE_CHECK, 8'h00, 32'h7FFF_FFEF, 31'h0);          // everything expires

        // Random: time mostly runs forward and crosses the wrap point; adds, removes of
        // recently used ids and checks, with phases that fill or drain, plus noise.
        sim_now    = 32'hFFFF_FFFF - 32'($urandom_range(0, 30000));
        counted    = 0;
        add_weight = 45;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 59) == 0) add_weight = ($urandom_range(0, 1) != 0) ? 60 : 30;
            roll = $urandom_range(0, 99);
            k    = $urandom_range(0, 99);
            if (roll < add_weight) begin
                wid = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
                if (k < 5) begin
                    dly = '0;
                end else if (k < 10) begin
                    dly = 31'h7FFF_FFFF;
                end else if (k < 20) begin
                    dly = 31'($urandom_range(1, 32'h7FFF_FFFF));
                end else begin
                    dly = 31'($urandom_range(1, 400));
                end
                // some adds carry a slightly stale time stamp
                queue_req(MODE_ADD, wid,
                          sim_now - ((k % 7 == 0) ? 32'($urandom_range(0, 40)) : 32'd0), dly);
                if (dly != '0) begin
                    recent.push_back(wid);
                    if (recent.size() > 24) recent.delete(0);
                    counted++;
                end
            end else if (roll < add_weight + 20) begin
                if (recent.size() != 0 && $urandom_range(0, 3) != 0) begin
                    wid = recent[$urandom_range(0, recent.size() - 1)];
                end else begin
                    wid = 8'($urandom);
                end
                queue_req(MODE_REMOVE, wid, $urandom, 31'($urandom));
                counted++;
            end else if (roll < 97) begin
                if (k < 4) begin
                    // long jump to flush far deadlines
                    sim_now = sim_now + 32'($urandom_range(0, 32'h7FFF_FFFF));
                    queue_req(MODE_CHECK, 8'($urandom), sim_now, 31'($urandom));
                end else if (k < 9) begin
                    // out-of-sequence time stamp, leave the running time alone
                    queue_req(MODE_CHECK, 8'($urandom), $urandom, 31'($urandom));
                end else begin
                    sim_now = sim_now + 32'($urandom_range(0, 250));
                    queue_req(MODE_CHECK, 8'($urandom), sim_now, 31'($urandom));
                end
                counted++;
            end else begin
                queue_req(MODE_SPARE, 8'($urandom), $urandom, 31'($urandom));
            end
        end

        // hold reset low over the first rising edges, release it away from the rising edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // wait for every request to go out and every predicted result to come back
        while (request_backlog.size() != 0 || s_valid || due_results.size() != 0) begin
            @(negedge aclk);
        end
        draining = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb_top: %0d requests taken, %0d results checked", requests_taken,
                 results_seen);
        $display("tb_top: %0d waiters released, %0d new heads, %0d full, %0d not found",
                 releases_seen, became_head_cnt, full_seen, not_found_seen);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: %0d mismatches, %0d results never arrived", mismatches,
                     due_results.size());
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
